// ===== sv/bcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Blob centroid package
// Shared widths, codes, queue entry type and back-end states for the blob
// centroid and bounding box finder.
// ----------------------------------------------------------------------------
package bcb_pkg;

  localparam int PIXEL_W      = 8;
  localparam int CFG_W        = 11;
  localparam int CFG_INDEX_W  = 1;
  localparam int COORD_W      = 10;
  localparam int SUM_W        = 30;
  localparam int COUNT_W      = 21;
  localparam int QUEUE_DEPTH  = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [PIXEL_W-1:0] FG_LEVEL = 8'hFF;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One finished frame, handed from the front end to the back end.
  typedef struct packed {
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [COUNT_W-1:0] count;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] radius;
    logic               updated;
    logic               empty;
  } frame_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_HOLD
  } back_state_t;

endpackage

// ===== sv/bcb_front.sv =====
// ----------------------------------------------------------------------------
// Blob centroid front end
// Holds the frame size registers, tracks the raster position, accumulates
// foreground sums and the bounding box, and emits one entry per frame.
// ----------------------------------------------------------------------------
module bcb_front #(
  parameter int MAX_WIDTH  = bcb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bcb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bcb_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_ready,
  input  logic [bcb_pkg::PIXEL_W-1:0]      pixel_value,
  input  logic                             q_full,
  output logic                             q_push,
  output bcb_pkg::frame_entry_t            q_data
);
  import bcb_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0]   frame_width;
  logic [CFG_W-1:0]   frame_height;
  logic [XW-1:0]      col;
  logic [YW-1:0]      row;
  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [COUNT_W-1:0] count;
  logic [COORD_W-1:0] min_x;
  logic [COORD_W-1:0] max_x;
  logic [COORD_W-1:0] min_y;
  logic [COORD_W-1:0] max_y;
  logic [COORD_W-1:0] held_radius;

  logic [WW-1:0]      w_lim;
  logic [HW-1:0]      h_lim;
  logic [XW-1:0]      last_x;
  logic [YW-1:0]      last_y;
  logic               row_end;
  logic               frame_end;
  logic               fg;
  logic               accept;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [SUM_W-1:0]   sum_x_next;
  logic [SUM_W-1:0]   sum_y_next;
  logic [COUNT_W-1:0] count_next;
  logic [COORD_W-1:0] min_x_next;
  logic [COORD_W-1:0] max_x_next;
  logic [COORD_W-1:0] min_y_next;
  logic [COORD_W-1:0] max_y_next;
  logic [COORD_W-1:0] span_x;
  logic [COORD_W-1:0] span_y;
  logic               square;
  logic               empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(1024);
      frame_height <= CFG_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (frame_width == '0) begin
      w_lim = WW'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(frame_width);
    end
    if (frame_height == '0) begin
      h_lim = HW'(1);
    end else if (int'(frame_height) > MAX_HEIGHT) begin
      h_lim = HW'(MAX_HEIGHT);
    end else begin
      h_lim = HW'(frame_height);
    end
  end

  assign last_x    = XW'(w_lim - WW'(1));
  assign last_y    = YW'(h_lim - HW'(1));
  assign row_end   = (col >= last_x);
  assign frame_end = row_end && (row >= last_y);

  // Only the last pixel of a frame needs room in the queue.
  assign pixel_ready = !frame_end || !q_full;
  assign accept      = pixel_valid && pixel_ready;
  assign q_push      = accept && frame_end;

  always_comb begin
    fg         = (pixel_value == FG_LEVEL);
    cx         = COORD_W'(col);
    cy         = COORD_W'(row);
    sum_x_next = fg ? sum_x + SUM_W'(cx) : sum_x;
    sum_y_next = fg ? sum_y + SUM_W'(cy) : sum_y;
    count_next = fg ? count + COUNT_W'(1) : count;
    min_x_next = (fg && cx < min_x) ? cx : min_x;
    max_x_next = (fg && cx > max_x) ? cx : max_x;
    min_y_next = (fg && cy < min_y) ? cy : min_y;
    max_y_next = (fg && cy > max_y) ? cy : max_y;
    span_x     = max_x_next - min_x_next;
    span_y     = max_y_next - min_y_next;
    square     = (span_x == span_y);
    empty      = (count_next == '0);
  end

  always_comb begin
    q_data = '0;
    if (empty) begin
      q_data.radius = held_radius;
      q_data.empty  = 1'b1;
    end else begin
      q_data.sum_x   = sum_x_next;
      q_data.sum_y   = sum_y_next;
      q_data.count   = count_next;
      q_data.min_x   = min_x_next;
      q_data.max_x   = max_x_next;
      q_data.min_y   = min_y_next;
      q_data.max_y   = max_y_next;
      q_data.radius  = square ? span_x : held_radius;
      q_data.updated = square;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      count       <= '0;
      min_x       <= '1;
      max_x       <= '0;
      min_y       <= '1;
      max_y       <= '0;
      held_radius <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col   <= '0;
        row   <= '0;
        sum_x <= '0;
        sum_y <= '0;
        count <= '0;
        min_x <= '1;
        max_x <= '0;
        min_y <= '1;
        max_y <= '0;
        if (!empty && square) begin
          held_radius <= span_x;
        end
      end else begin
        sum_x <= sum_x_next;
        sum_y <= sum_y_next;
        count <= count_next;
        min_x <= min_x_next;
        max_x <= max_x_next;
        min_y <= min_y_next;
        max_y <= max_y_next;
        if (row_end) begin
          col <= '0;
          row <= row + YW'(1);
        end else begin
          col <= col + XW'(1);
        end
      end
    end
  end

endmodule

// ===== sv/bcb_fifo.sv =====
// ----------------------------------------------------------------------------
// Blob centroid frame queue
// Short queue of finished frame entries between the front and back ends.
// ----------------------------------------------------------------------------
module bcb_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bcb_pkg::frame_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output bcb_pkg::frame_entry_t pop_data,
  output logic                  not_empty
);
  import bcb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_entry_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/bcb_div.sv =====
// ----------------------------------------------------------------------------
// Blob centroid divider
// Restoring divider, one quotient bit per cycle; keeps the low quotient bits.
// ----------------------------------------------------------------------------
module bcb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bcb_pkg::SUM_W-1:0]   dividend,
  input  logic [bcb_pkg::COUNT_W-1:0] divisor,
  output logic                        done,
  output logic [bcb_pkg::COORD_W-1:0] quotient
);
  import bcb_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic                active;
  logic [STEP_W-1:0]   step;
  logic [SUM_W-1:0]    num;
  logic [COUNT_W-1:0]  den;
  logic [COUNT_W-1:0]  rem;
  logic [COORD_W-1:0]  quo;
  logic [COUNT_W:0]    trial;
  logic [COUNT_W:0]    diff;
  logic                fits;
  logic [COUNT_W-1:0]  rem_next;

  // The partial remainder stays below the divisor, so the difference fits.
  always_comb begin
    trial    = {rem, num[SUM_W-1]};
    diff     = trial - {1'b0, den};
    fits     = (trial >= {1'b0, den});
    rem_next = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
        num    <= dividend;
        den    <= divisor;
        rem    <= '0;
      end else if (active) begin
        num  <= num << 1;
        rem  <= rem_next;
        quo  <= {quo[COORD_W-2:0], fits};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/bcb_back.sv =====
// ----------------------------------------------------------------------------
// Blob centroid back end
// Takes frame entries from the queue, divides the sums by the count unless
// the frame is empty, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module bcb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  bcb_pkg::frame_entry_t       q_data,
  output logic                        q_pop,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [bcb_pkg::COORD_W-1:0] center_x,
  output logic [bcb_pkg::COORD_W-1:0] center_y,
  output logic [bcb_pkg::COORD_W-1:0] box_min_x,
  output logic [bcb_pkg::COORD_W-1:0] box_max_x,
  output logic [bcb_pkg::COORD_W-1:0] box_min_y,
  output logic [bcb_pkg::COORD_W-1:0] box_max_y,
  output logic [bcb_pkg::COORD_W-1:0] radius_out,
  output logic                        radius_updated,
  output logic [bcb_pkg::COUNT_W-1:0] pixel_count,
  output logic                        frame_empty
);
  import bcb_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  frame_entry_t       job;
  logic [COORD_W-1:0] cx_q;
  logic [COORD_W-1:0] cy_q;
  logic               div_start;
  logic               done_x;
  logic               done_y;
  logic [COORD_W-1:0] quo_x;
  logic [COORD_W-1:0] quo_y;

  bcb_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_data.sum_x),
    .divisor  (q_data.count),
    .done     (done_x),
    .quotient (quo_x)
  );

  bcb_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_data.sum_y),
    .divisor  (q_data.count),
    .done     (done_y),
    .quotient (quo_y)
  );

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = q_data.empty ? BK_HOLD : BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (done_x && done_y) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (result_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (state == BK_IDLE) && q_valid;
    div_start    = q_pop && !q_data.empty;
    result_valid = (state == BK_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
      if (q_pop) begin
        job  <= q_data;
        cx_q <= '0;
        cy_q <= '0;
      end else if (state == BK_DIVIDE && done_x && done_y) begin
        cx_q <= quo_x;
        cy_q <= quo_y;
      end
    end
  end

  assign center_x       = cx_q;
  assign center_y       = cy_q;
  assign box_min_x      = job.min_x;
  assign box_max_x      = job.max_x;
  assign box_min_y      = job.min_y;
  assign box_max_y      = job.max_y;
  assign radius_out     = job.radius;
  assign radius_updated = job.updated;
  assign pixel_count    = job.count;
  assign frame_empty    = job.empty;

endmodule

// ===== sv/blob_centroid_bbox_finder.sv =====
// ----------------------------------------------------------------------------
// Blob centroid and bounding box finder
// Finds the centroid, bounding box and square-box radius of the 255-valued
// pixels of each raster-order grayscale frame.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on the pixel channel (pixel_valid/pixel_ready/pixel_value),
// one item per pixel in raster order; the block counts columns and rows
// itself from frame_width and frame_height. The user is to write those two
// registers through the cfg channel (index 0 is the width, index 1 the
// height) only while the block is idle; the block itself does not enforce
// this. cfg_ready is always high. Only the last pixel of a frame makes a
// result item: it is placed in a two-entry frame queue, and the back end
// then runs two 30-step restoring dividers in parallel (an empty frame
// skips them) before the result is held on the result channel. The back
// end takes the next entry from the queue only once that result is taken.
// While the back end divides or waits on result_ready, the front end keeps
// taking the pixels of the next frame; it stalls only on a frame's last
// pixel when the queue is full. A result stays on the outputs, unchanged,
// until result_ready takes it.
// Reset sets the frame size to 1024 by 1024, clears the position, sums,
// count, box and held radius, and empties the queue.
// ----------------------------------------------------------------------------
module blob_centroid_bbox_finder #(
  parameter int MAX_WIDTH  = bcb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bcb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bcb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bcb_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  logic [bcb_pkg::PIXEL_W-1:0]     pixel_value,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [bcb_pkg::COORD_W-1:0]     center_x,
  output logic [bcb_pkg::COORD_W-1:0]     center_y,
  output logic [bcb_pkg::COORD_W-1:0]     box_min_x,
  output logic [bcb_pkg::COORD_W-1:0]     box_max_x,
  output logic [bcb_pkg::COORD_W-1:0]     box_min_y,
  output logic [bcb_pkg::COORD_W-1:0]     box_max_y,
  output logic [bcb_pkg::COORD_W-1:0]     radius_out,
  output logic                            radius_updated,
  output logic [bcb_pkg::COUNT_W-1:0]     pixel_count,
  output logic                            frame_empty
);
  import bcb_pkg::*;

  // Frame entries flow front end -> queue -> back end.
  frame_entry_t push_data;
  frame_entry_t pop_data;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;

  // Front end: position tracking, accumulation and radius bookkeeping.
  bcb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_value (pixel_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  // Queue of finished frames so each side can stall on its own.
  bcb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  // Back end: centroid division and the held result.
  bcb_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_data         (pop_data),
    .q_pop          (q_pop),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .center_x       (center_x),
    .center_y       (center_y),
    .box_min_x      (box_min_x),
    .box_max_x      (box_max_x),
    .box_min_y      (box_min_y),
    .box_max_y      (box_max_y),
    .radius_out     (radius_out),
    .radius_updated (radius_updated),
    .pixel_count    (pixel_count),
    .frame_empty    (frame_empty)
  );

endmodule
